// File: hw/rtl/tgq_pkg.sv
// Package for the touch gesture qualifier: field widths, register indexes,
// event codes and the packed request, event and state types.
// No dependencies.
package tgq_pkg;

    localparam int COORD_W = 12;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int THR_W   = 12;
    localparam int CFG_W   = 16;

    localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = DELAY_W'(50);
    localparam logic [THR_W-1:0]   MOVE_THRESHOLD_RST = THR_W'(3);

    typedef enum logic {
        REG_RELEASE_DELAY  = 1'b0,
        REG_MOVE_THRESHOLD = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_TOUCH   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_MOVE    = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic               touching;
        logic [COORD_W-1:0] sample_x;
        logic [COORD_W-1:0] sample_y;
        logic [TIME_W-1:0]  now_ms;
    } t_sample;

    typedef struct packed {
        t_event_kind        event_kind;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
    } t_event;

    typedef struct packed {
        logic               pressed;
        logic [TIME_W-1:0]  last_time;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [COORD_W-1:0] latest_x;
        logic [COORD_W-1:0] latest_y;
    } t_tgq_state;

endpackage

// File: hw/rtl/tgq_eval.sv
// Combinational evaluation of one touch sample against the current gesture state.
// Produces the next state and at most one event. Depends on tgq_pkg.
module tgq_eval (
    input  tgq_pkg::t_sample                  i_sample,
    input  tgq_pkg::t_tgq_state               i_state,
    input  logic [tgq_pkg::DELAY_W-1:0]       i_release_delay,
    input  logic [tgq_pkg::THR_W-1:0]         i_move_threshold,
    output tgq_pkg::t_tgq_state               o_state,
    output logic                              o_emit,
    output tgq_pkg::t_event                   o_event
);
    import tgq_pkg::*;

    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [TIME_W-1:0]  elapsed;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] max_delta;
    logic               timed_out;
    logic               moved;

    assign cur_x = i_sample.touching ? i_sample.sample_x : i_state.latest_x;
    assign cur_y = i_sample.touching ? i_sample.sample_y : i_state.latest_y;

    // Modular subtraction keeps the timeout correct across timestamp wrap.
    assign elapsed   = i_sample.now_ms - i_state.last_time;
    assign timed_out = elapsed > TIME_W'(i_release_delay);

    assign dx   = (i_state.last_x > cur_x) ? i_state.last_x - cur_x : cur_x - i_state.last_x;
    assign dy   = (i_state.last_y > cur_y) ? i_state.last_y - cur_y : cur_y - i_state.last_y;
    assign max_delta = (dx > dy) ? dx : dy;
    assign moved = max_delta > COORD_W'(i_move_threshold);

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        o_event = '{event_kind: EV_MOVE, from_x: i_state.last_x, from_y: i_state.last_y,
                    to_x: cur_x, to_y: cur_y};
        if (i_sample.touching || i_state.pressed) begin
            if (i_sample.touching) begin
                o_state.last_time = i_sample.now_ms;
                o_state.latest_x  = cur_x;
                o_state.latest_y  = cur_y;
            end
            if (i_sample.touching && !i_state.pressed) begin
                o_state.pressed = 1'b1;
                o_state.first_x = cur_x;
                o_state.first_y = cur_y;
                o_state.last_x  = cur_x;
                o_state.last_y  = cur_y;
                o_emit          = 1'b1;
                o_event = '{event_kind: EV_TOUCH, from_x: '0, from_y: '0,
                            to_x: cur_x, to_y: cur_y};
            end else if (!i_sample.touching && timed_out) begin
                o_state.pressed = 1'b0;
                o_state.last_x  = cur_x;
                o_state.last_y  = cur_y;
                o_emit          = 1'b1;
                o_event = '{event_kind: EV_RELEASE, from_x: i_state.first_x,
                            from_y: i_state.first_y, to_x: cur_x, to_y: cur_y};
            end else if (moved) begin
                o_state.last_x = cur_x;
                o_state.last_y = cur_y;
                o_emit         = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/touch_gesture_qualifier.sv
// Top level of the touch gesture qualifier: handshake, input and event registers,
// gesture state and configuration registers. Depends on tgq_pkg and tgq_eval.
//
//   channel   direction  handshake                     payload
//   in        input      i_in_valid / o_in_ready       i_in_data  (t_sample)
//   out       output     o_out_valid / i_out_ready     o_out_data (t_event)
//   cfg       input      i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One sample per cycle is accepted while the input register is free or being evaluated; a sample is
// held in the input register, evaluated from there, and its event, if any, is registered in the event register.
// The gesture state updates in the same cycle that the sample is evaluated, so the
// next sample sees it at once. A stalled event holds the evaluation stage, and the
// input register keeps accepting until it is occupied. Reset is synchronous, active
// low, and clears the state and loads the default release delay and move threshold.
module touch_gesture_qualifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tgq_pkg::t_sample             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tgq_pkg::t_event              o_out_data,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [tgq_pkg::CFG_W-1:0]    i_cfg_data
);
    import tgq_pkg::*;

    logic               r_in_vld;
    t_sample            r_in;
    t_tgq_state         r_st;
    logic               r_out_vld;
    t_event             r_out;
    logic [DELAY_W-1:0] r_release_delay;
    logic [THR_W-1:0]   r_move_threshold;

    t_tgq_state         n_st;
    logic               emit;
    t_event             ev;
    logic               proc;

    tgq_eval u_eval (
        .i_sample         (r_in),
        .i_state          (r_st),
        .i_release_delay  (r_release_delay),
        .i_move_threshold (r_move_threshold),
        .o_state          (n_st),
        .o_emit           (emit),
        .o_event          (ev)
    );

    // The buffered request is evaluated once the event register is free or draining.
    assign proc       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || proc;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (proc) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc) begin
            r_out_vld <= emit;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (proc && emit) begin
            r_out <= ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_delay  <= RELEASE_DELAY_RST;
            r_move_threshold <= MOVE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RELEASE_DELAY:  r_release_delay  <= i_cfg_data[DELAY_W-1:0];
                REG_MOVE_THRESHOLD: r_move_threshold <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A touch event can only start from the released state.
    a_touch_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && emit && ev.event_kind == EV_TOUCH |-> !r_st.pressed)
        else $error("touch event while already pressed");

    // A release event leaves the qualifier released.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && emit && ev.event_kind == EV_RELEASE |=> !r_st.pressed)
        else $error("pressed still set after release");

    // A waiting event is never overwritten by a new evaluation.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |-> !proc)
        else $error("event register overwritten while stalled");

    // State changes only when a request is evaluated.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> $stable(r_st))
        else $error("gesture state changed without a request");

endmodule
